>>> hdl/mpd_pkg.sv
// Package for the max pool downscaler: shared widths, defaults, register
// indexes and the structs that pass between its modules. No dependencies.
package mpd_pkg;

  localparam int MAX_LINE_DEF   = 4096;
  localparam int MAX_FACTOR_DEF = 16;
  localparam int PIXEL_BITS_DEF = 8;

  localparam int MAX_LINES  = 4096;
  localparam int FACTOR_W   = 5;
  localparam int LEN_W      = 13;
  localparam int ADDR_W     = 4;
  localparam int DATA_W     = 32;

  localparam logic [1:0] REG_FACTOR = 2'd0;
  localparam logic [1:0] REG_LENGTH = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  localparam logic [FACTOR_W-1:0] FACTOR_RST = FACTOR_W'(2);
  localparam logic [LEN_W-1:0]    LENGTH_RST = LEN_W'(4096);
  localparam logic [LEN_W-1:0]    COUNT_RST  = LEN_W'(4096);

  // clamped geometry
  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic [LEN_W-1:0]    length;
    logic [LEN_W-1:0]    count;
  } cfg_t;

  // per-pixel control from the scan stage to the merge stage
  typedef struct packed {
    logic write;
    logic emit;
    logic last;
    logic first_row;
  } scan_ctl_t;

endpackage

>>> hdl/mpd_if.sv
// Stream interfaces of the max pool downscaler: pixel input and pooled output.
// Depends on mpd_pkg.
interface mpd_pixel_if #(parameter int PIXEL_BITS = mpd_pkg::PIXEL_BITS_DEF) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface mpd_pool_if #(parameter int PIXEL_BITS = mpd_pkg::PIXEL_BITS_DEF) ();
  logic                  valid;
  logic                  ready;
  logic [PIXEL_BITS-1:0] pooled;
  logic                  image_done;
  modport source (output valid, output pooled, output image_done, input ready);
  modport sink (input valid, input pooled, input image_done, output ready);
endinterface

>>> hdl/mpd_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module mpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/mpd_cfg.sv
// APB register file of the max pool downscaler; clamps the geometry and
// flags an image restart on every register write. Depends on mpd_pkg.
module mpd_cfg #(
  parameter int MAX_LINE   = mpd_pkg::MAX_LINE_DEF,
  parameter int MAX_FACTOR = mpd_pkg::MAX_FACTOR_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mpd_pkg::ADDR_W-1:0]  paddr,
  input  logic [mpd_pkg::DATA_W-1:0]  pwdata,
  output logic [mpd_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output mpd_pkg::cfg_t               cfg,
  output logic                        restart
);
  import mpd_pkg::*;

  logic [FACTOR_W-1:0] factor;
  logic [LEN_W-1:0]    length;
  logic [LEN_W-1:0]    count;
  logic                wr;
  logic [1:0]          idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= FACTOR_RST;
      length <= LENGTH_RST;
      count  <= COUNT_RST;
    end else if (wr) begin
      case (idx)
        REG_FACTOR: factor <= pwdata[FACTOR_W-1:0];
        REG_LENGTH: length <= pwdata[LEN_W-1:0];
        REG_COUNT:  count  <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    restart = 1'b0;
    if (wr) begin
      case (idx)
        REG_FACTOR, REG_LENGTH, REG_COUNT: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FACTOR: prdata = DATA_W'(factor);
      REG_LENGTH: prdata = DATA_W'(length);
      REG_COUNT:  prdata = DATA_W'(count);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (factor == '0) begin
      cfg.factor = FACTOR_W'(1);
    end else if (32'(factor) > MAX_FACTOR) begin
      cfg.factor = FACTOR_W'(MAX_FACTOR);
    end else begin
      cfg.factor = factor;
    end
    if (length == '0) begin
      cfg.length = LEN_W'(1);
    end else if (32'(length) > MAX_LINE) begin
      cfg.length = LEN_W'(MAX_LINE);
    end else begin
      cfg.length = length;
    end
    if (count == '0) begin
      cfg.count = LEN_W'(1);
    end else if (32'(count) > MAX_LINES) begin
      cfg.count = LEN_W'(MAX_LINES);
    end else begin
      cfg.count = count;
    end
  end

endmodule

>>> hdl/mpd_scan.sv
// Scan position tracking of the max pool downscaler: line and block counters,
// running maximum along the line, line store address. Depends on mpd_pkg.
module mpd_scan #(
  parameter int MAX_LINE   = mpd_pkg::MAX_LINE_DEF,
  parameter int PIXEL_BITS = mpd_pkg::PIXEL_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  mpd_pkg::cfg_t               cfg,
  input  logic                        restart,
  input  logic                        accept,
  input  logic [PIXEL_BITS-1:0]       pixel,
  output mpd_pkg::scan_ctl_t          ctl,
  output logic [$clog2(MAX_LINE)-1:0] addr,
  output logic [PIXEL_BITS-1:0]       max_out
);
  import mpd_pkg::*;

  localparam int AW    = $clog2(MAX_LINE);
  localparam int POS_W = LEN_W + 1;

  logic [LEN_W-1:0]      along, along_next;
  logic [LEN_W-1:0]      line, line_next;
  logic [FACTOR_W-1:0]   in_along, in_along_next;
  logic [FACTOR_W-1:0]   in_across, in_across_next;
  logic [AW-1:0]         column, column_next;
  logic [LEN_W-1:0]      blk_start, blk_start_next;
  logic [LEN_W-1:0]      row_start, row_start_next;
  logic [PIXEL_BITS-1:0] rmax, rmax_next;

  logic [POS_W-1:0]      f_ext, col_end, row_end;
  logic                  use_px, blk_last, along_wrap, line_wrap, across_wrap;
  logic [PIXEL_BITS-1:0] m;

  assign f_ext    = POS_W'(cfg.factor);
  assign col_end  = POS_W'(blk_start) + f_ext;
  assign row_end  = POS_W'(row_start) + f_ext;
  assign use_px   = (col_end <= POS_W'(cfg.length)) && (row_end <= POS_W'(cfg.count));
  assign m        = (in_along == '0 || pixel > rmax) ? pixel : rmax;
  assign blk_last = (FACTOR_W'(in_along + 1'b1) == cfg.factor);

  assign along_wrap  = (POS_W'(along) + POS_W'(1)) >= POS_W'(cfg.length);
  assign line_wrap   = (POS_W'(line) + POS_W'(1)) >= POS_W'(cfg.count);
  assign across_wrap = ((FACTOR_W + 1)'(in_across) + (FACTOR_W + 1)'(1))
                       >= (FACTOR_W + 1)'(cfg.factor);

  assign ctl.write     = use_px && blk_last;
  assign ctl.emit      = use_px && blk_last && (FACTOR_W'(in_across + 1'b1) == cfg.factor);
  assign ctl.first_row = (in_across == '0);
  assign ctl.last      = ((col_end + f_ext) > POS_W'(cfg.length))
                         && ((row_end + f_ext) > POS_W'(cfg.count));
  assign addr          = column;
  assign max_out       = m;

  always_comb begin
    along_next     = along;
    line_next      = line;
    in_along_next  = in_along;
    in_across_next = in_across;
    column_next    = column;
    blk_start_next = blk_start;
    row_start_next = row_start;
    rmax_next      = rmax;
    if (accept) begin
      if (use_px) begin
        rmax_next = m;
      end
      if (along_wrap) begin
        along_next     = '0;
        in_along_next  = '0;
        column_next    = '0;
        blk_start_next = '0;
        if (line_wrap) begin
          line_next      = '0;
          in_across_next = '0;
          row_start_next = '0;
        end else begin
          line_next = line + 1'b1;
          if (across_wrap) begin
            in_across_next = '0;
            row_start_next = row_start + LEN_W'(cfg.factor);
          end else begin
            in_across_next = in_across + 1'b1;
          end
        end
      end else begin
        along_next = along + 1'b1;
        if (blk_last) begin
          in_along_next  = '0;
          column_next    = column + 1'b1;
          blk_start_next = blk_start + LEN_W'(cfg.factor);
        end else begin
          in_along_next = in_along + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      along     <= '0;
      line      <= '0;
      in_along  <= '0;
      in_across <= '0;
      column    <= '0;
      blk_start <= '0;
      row_start <= '0;
      rmax      <= '0;
    end else begin
      along     <= along_next;
      line      <= line_next;
      in_along  <= in_along_next;
      in_across <= in_across_next;
      column    <= column_next;
      blk_start <= blk_start_next;
      row_start <= row_start_next;
      rmax      <= rmax_next;
    end
  end

endmodule

>>> hdl/max_pool_downscaler.sv
// Top level of the max pool downscaler: APB registers, scan stage, line store
// and merge stage. Depends on mpd_pkg, mpd_if, mpd_ram, mpd_cfg, mpd_scan.
//
// Takes one pixel per cycle in scan order and gives the maximum of each
// pool_factor-by-pool_factor block, with image_done on the last block of the
// image. The scan stage updates the counters and the running maximum and reads
// the line store; the merge stage then merges the stored partial maximum, writes
// it back and loads the output register. A write and a read of the same store
// entry in one cycle are
// forwarded. The input stalls only while a result waits in the output register
// and another result is ready behind it. Any register write restarts the image.
module max_pool_downscaler #(
  parameter int MAX_LINE   = mpd_pkg::MAX_LINE_DEF,
  parameter int MAX_FACTOR = mpd_pkg::MAX_FACTOR_DEF,
  parameter int PIXEL_BITS = mpd_pkg::PIXEL_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mpd_pkg::ADDR_W-1:0] paddr,
  input  logic [mpd_pkg::DATA_W-1:0] pwdata,
  output logic [mpd_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  mpd_pixel_if.sink                  pixels,
  mpd_pool_if.source                 results
);
  import mpd_pkg::*;

  localparam int AW = $clog2(MAX_LINE);

  cfg_t                  cfg;
  logic                  restart;
  scan_ctl_t             scan_ctl, s1_ctl;
  logic [AW-1:0]         scan_addr, s1_addr;
  logic [PIXEL_BITS-1:0] scan_max, s1_m;
  logic                  accept, s1_valid, s1_adv;
  logic [PIXEL_BITS-1:0] rd_data, stored, merged, fwd_data;
  logic                  fwd_hit, wr_en;
  logic                  out_valid, out_done;
  logic [PIXEL_BITS-1:0] out_pooled;

  mpd_cfg #(
    .MAX_LINE  (MAX_LINE),
    .MAX_FACTOR(MAX_FACTOR)
  ) u_cfg (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg    (cfg),
    .restart(restart)
  );

  mpd_scan #(
    .MAX_LINE  (MAX_LINE),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .restart(restart),
    .accept (accept),
    .pixel  (pixels.pixel),
    .ctl    (scan_ctl),
    .addr   (scan_addr),
    .max_out(scan_max)
  );

  mpd_ram #(
    .WIDTH(PIXEL_BITS),
    .DEPTH(MAX_LINE)
  ) u_line (
    .clk  (clk),
    .we   (wr_en),
    .waddr(s1_addr),
    .wdata(merged),
    .re   (accept),
    .raddr(scan_addr),
    .rdata(rd_data)
  );

  assign s1_adv       = !s1_valid || !s1_ctl.emit || !out_valid || results.ready;
  assign pixels.ready = s1_adv;
  assign accept       = pixels.valid && s1_adv;

  assign stored = fwd_hit ? fwd_data : rd_data;
  assign merged = (!s1_ctl.first_row && stored > s1_m) ? stored : s1_m;
  assign wr_en  = s1_valid && s1_ctl.write && s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ctl   <= scan_ctl;
      s1_m     <= scan_max;
      s1_addr  <= scan_addr;
      fwd_hit  <= wr_en && (s1_addr == scan_addr);
      fwd_data <= merged;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_ctl.emit && s1_adv) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_ctl.emit && s1_adv) begin
      out_pooled <= merged;
      out_done   <= s1_ctl.last;
    end
  end

  assign results.valid      = out_valid;
  assign results.pooled     = out_pooled;
  assign results.image_done = out_done;

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for max_pool_downscaler: streams pixels under random
// gaps and stalls and checks every pooled pixel against a local block-max model.
// Depends on mpd_pkg, mpd_if and the RTL of the block.
module tb;
  import mpd_pkg::*;

  localparam int PB = PIXEL_BITS_DEF;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_PIXELS = 600;

  typedef struct packed {
    logic [PB-1:0] pooled;
    logic          image_done;
  } pool_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  mpd_pixel_if pixels_if ();
  mpd_pool_if  results_if ();

  max_pool_downscaler dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .pixels  (pixels_if),
    .results (results_if)
  );

  // block-max model state
  logic [FACTOR_W-1:0] factor_reg;
  logic [LEN_W-1:0]    length_reg;
  logic [LEN_W-1:0]    count_reg;
  logic [PB-1:0]       block_max_line [MAX_LINE_DEF];
  int                  scan_col;
  int                  scan_line;
  int                  col_in_block;
  int                  line_in_block;
  int                  block_idx;
  logic [PB-1:0]       row_max;

  logic [PB-1:0] pixel_queue [$];
  pool_t         expected_pool [$];
  int            errors;
  int            cycle_count;
  int            pixel_gap;
  int            ready_stall;
  bit            steady_source;
  bit            steady_sink;

  function automatic int clamp_geom(int v, int hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void restart_scan();
    scan_col = 0;
    scan_line = 0;
    col_in_block = 0;
    line_in_block = 0;
    block_idx = 0;
    row_max = '0;
  endfunction

  function automatic void pool_pixel(logic [PB-1:0] px);
    int f;
    int len;
    int cnt;
    int blocks_across;
    int rows_used;
    logic [PB-1:0] m;
    f = clamp_geom(factor_reg, MAX_FACTOR_DEF);
    len = clamp_geom(length_reg, MAX_LINE_DEF);
    cnt = clamp_geom(count_reg, MAX_LINES);
    blocks_across = len / f;
    rows_used = (cnt / f) * f;
    if (block_idx < blocks_across && scan_line < rows_used) begin
      m = (col_in_block == 0 || px > row_max) ? px : row_max;
      row_max = m;
      if (col_in_block == f - 1) begin
        if (line_in_block != 0 && block_max_line[block_idx] > m) m = block_max_line[block_idx];
        block_max_line[block_idx] = m;
        if (line_in_block == f - 1)
          expected_pool.push_back('{pooled: m,
            image_done: (block_idx == blocks_across - 1) && (scan_line == rows_used - 1)});
      end
    end
    col_in_block++;
    if (col_in_block >= f) begin
      col_in_block = 0;
      block_idx++;
    end
    scan_col++;
    if (scan_col >= len) begin
      scan_col = 0;
      col_in_block = 0;
      block_idx = 0;
      line_in_block++;
      if (line_in_block >= f) line_in_block = 0;
      scan_line++;
      if (scan_line >= cnt) begin
        scan_line = 0;
        line_in_block = 0;
      end
    end
  endfunction

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_source || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic int next_stall();
    int r;
    r = $urandom_range(0, 99);
    if (steady_sink || r < 80) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 20);
  endfunction

  function automatic logic [PB-1:0] rand_pixel();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return PB'($urandom_range(0, 255));
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 30)
      $display("ERROR cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout with %0d pooled pixels outstanding", expected_pool.size());
      $display("max_pool_downscaler: mismatch");
      $finish;
    end
  end

  // pixel source
  always @(posedge clk) begin
    if (rst) begin
      pixels_if.valid <= 1'b0;
      pixel_gap <= 0;
    end else if (!pixels_if.valid || pixels_if.ready) begin
      if (pixel_gap != 0) begin
        pixels_if.valid <= 1'b0;
        pixel_gap <= pixel_gap - 1;
      end else if (pixel_queue.size() != 0) begin
        pixels_if.valid <= 1'b1;
        pixels_if.pixel <= pixel_queue.pop_front();
        pixel_gap <= next_gap();
      end else begin
        pixels_if.valid <= 1'b0;
      end
    end
  end

  // result sink
  always @(posedge clk) begin
    if (rst) begin
      results_if.ready <= 1'b0;
      ready_stall <= 0;
    end else if (ready_stall != 0) begin
      results_if.ready <= 1'b0;
      ready_stall <= ready_stall - 1;
    end else begin
      results_if.ready <= 1'b1;
      ready_stall <= next_stall();
    end
  end

  always @(posedge clk) begin : monitor
    pool_t want;
    if (!rst) begin
      if (results_if.valid && results_if.ready) begin
        if (expected_pool.size() == 0) begin
          report_mismatch("unexpected pooled pixel", results_if.pooled, -1);
        end else begin
          want = expected_pool.pop_front();
          if (results_if.pooled !== want.pooled)
            report_mismatch("pooled", results_if.pooled, want.pooled);
          if (results_if.image_done !== want.image_done)
            report_mismatch("image_done", results_if.image_done, want.image_done);
        end
      end
      if (pixels_if.valid && pixels_if.ready) pool_pixel(pixels_if.pixel);
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FACTOR: factor_reg = value[FACTOR_W-1:0];
      REG_LENGTH: length_reg = value[LEN_W-1:0];
      REG_COUNT:  count_reg = value[LEN_W-1:0];
      default: ;
    endcase
    restart_scan();
  endtask

  task automatic configure(input int f, input int len, input int cnt);
    write_reg(REG_FACTOR, f);
    write_reg(REG_LENGTH, len);
    write_reg(REG_COUNT, cnt);
  endtask

  // idle: nothing queued or in flight, then room for a request that gives no result
  task automatic drain();
    @(negedge clk);
    while (pixel_queue.size() != 0 || pixels_if.valid || expected_pool.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic feed_random(input int n);
    repeat (n) pixel_queue.push_back(rand_pixel());
  endtask

  initial begin : stimulus
    int f;
    int len;
    int cnt;
    int image;
    int n;
    int fed;
    int phase;
    pixels_if.valid = 1'b0;
    pixels_if.pixel = '0;
    results_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst = 1'b1;
    cycle_count = 0;
    errors = 0;
    steady_source = 1'b0;
    steady_sink = 1'b0;
    factor_reg = FACTOR_RST;
    length_reg = LENGTH_RST;
    count_reg = COUNT_RST;
    restart_scan();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: single-pixel blocks at the pixel extremes
    configure(1, 2, 2);
    pixel_queue.push_back(8'd0);
    pixel_queue.push_back(8'd255);
    pixel_queue.push_back(8'd128);
    pixel_queue.push_back(8'd1);
    drain();
    // zero factor, length and count act as one
    configure(0, 0, 0);
    pixel_queue.push_back(8'd7);
    pixel_queue.push_back(8'd200);
    drain();
    // trailing column and row are dropped
    configure(2, 3, 3);
    pixel_queue.push_back(8'd5);
    pixel_queue.push_back(8'd3);
    pixel_queue.push_back(8'd255);
    pixel_queue.push_back(8'd1);
    pixel_queue.push_back(8'd9);
    pixel_queue.push_back(8'd255);
    repeat (3) pixel_queue.push_back(8'd255);
    drain();
    // oversized factor saturates and exceeds the image: no block
    configure(31, 4, 4);
    repeat (4) pixel_queue.push_back(8'd255);
    drain();
    // a register write mid-image restarts the scan
    configure(2, 2, 2);
    pixel_queue.push_back(8'd255);
    pixel_queue.push_back(8'd255);
    drain();
    configure(2, 2, 2);
    pixel_queue.push_back(8'd0);
    pixel_queue.push_back(8'd1);
    pixel_queue.push_back(8'd2);
    pixel_queue.push_back(8'd3);
    drain();

    // large geometry, reset defaults first
    steady_source = 1'b1;
    restart_scan();
    configure(FACTOR_RST, LENGTH_RST, COUNT_RST);
    feed_random(60);
    drain();
    configure(1, 8191, 8191);
    feed_random(60);
    drain();
    configure(1, 1, 8191);
    feed_random(60);
    drain();
    configure(1, 4096, 1);
    feed_random(60);
    drain();
    configure(16, 16, 4096);
    feed_random(256);
    drain();

    fed = 0;
    phase = 0;
    while (fed < RANDOM_PIXELS) begin
      steady_source = ($urandom_range(0, 4) == 0);
      steady_sink = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: f = $urandom_range(1, 4);
        6, 7: f = $urandom_range(5, 16);
        8: f = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
        default: f = 16;
      endcase
      case ($urandom_range(0, 19))
        0: len = 0;
        1, 2: len = $urandom_range(4000, 8191);
        default: len = $urandom_range(1, 48);
      endcase
      case ($urandom_range(0, 19))
        0: cnt = 0;
        1: cnt = $urandom_range(4096, 8191);
        default: cnt = $urandom_range(1, 40);
      endcase
      configure(f, len, cnt);
      image = clamp_geom(len, MAX_LINE_DEF) * clamp_geom(cnt, MAX_LINES);
      if (image <= 400) begin
        n = image * $urandom_range(1, 3);
        if (n > 450) n = image;
        if ($urandom_range(0, 9) < 3) n += $urandom_range(1, image);
      end else begin
        n = $urandom_range(50, 300);
      end
      if (phase % 3 == 1) begin
        // source holds off until every pooled pixel so far is back
        feed_random(n / 2);
        drain();
        feed_random(n - n / 2);
      end else begin
        feed_random(n);
      end
      drain();
      fed += n;
      phase++;
    end

    @(negedge clk);
    while (pixel_queue.size() != 0 || pixels_if.valid || expected_pool.size() != 0)
      @(negedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("max_pool_downscaler: match");
    else $display("max_pool_downscaler: mismatch");
    $finish;
  end

endmodule
